// ===== rtl/bgtr_pkg.sv =====
// Shared types and constants for the bitmap glyph text renderer.
// Used by the core and the glyph store.
package bgtr_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_METRICS = 2'd0,
    OP_LOAD_ROW     = 2'd1,
    OP_BEGIN_TEXT   = 2'd2,
    OP_DRAW_CHAR    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_START_X      = 2'd0,
    CFG_START_Y      = 2'd1,
    CFG_IMAGE_WIDTH  = 2'd2,
    CFG_IMAGE_HEIGHT = 2'd3
  } cfg_reg_t;

  localparam int MAX_GLYPH_WIDTH  = 16;
  localparam int MAX_GLYPH_HEIGHT = 16;
  localparam int ROWS_PER_GLYPH   = 16;
  localparam int ROW_BITS_W       = 16;
  localparam int ROW_IDX_W        = 4;
  localparam int WIDTH_LIMIT      = (MAX_GLYPH_WIDTH < 16) ? MAX_GLYPH_WIDTH : 16;
  localparam int HEIGHT_LIMIT     = (MAX_GLYPH_HEIGHT < 16) ? MAX_GLYPH_HEIGHT : 16;
  localparam logic [4:0]  W_LIM   = 5'(WIDTH_LIMIT);
  localparam logic [4:0]  H_LIM   = 5'(HEIGHT_LIMIT);
  localparam logic [12:0] Y_LIMIT = 13'd4096;

  // One glyph metric entry as kept in the metric store.
  typedef struct packed {
    logic              present;
    logic [4:0]        glyph_width;
    logic [4:0]        glyph_height;
    logic signed [7:0] x_offset;
    logic signed [7:0] y_offset;
    logic signed [7:0] advance_x;
  } metric_t;

  // Control strobes from the sequencer to the glyph store.
  typedef struct packed {
    logic wr_metric;
    logic wr_row;
    logic rd_metric;
  } store_ctl_t;

endpackage

// ===== rtl/bgtr_glyph_store.sv =====
// Glyph store: metric memory with per-entry valid bits and the bitmap row memory.
// Depends on bgtr_pkg for the metric entry and control types.
module bgtr_glyph_store import bgtr_pkg::*; #(
  parameter int GLYPH_COUNT = 256,
  parameter int IDX_W       = $clog2(GLYPH_COUNT)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  store_ctl_t            ctl,
  input  logic [IDX_W-1:0]      wr_idx,
  input  logic [ROW_IDX_W-1:0]  wr_row,
  input  logic [ROW_BITS_W-1:0] wr_bits,
  input  metric_t               wr_metric,
  input  logic [IDX_W-1:0]      rd_idx,
  input  logic [ROW_IDX_W-1:0]  rd_row,
  output metric_t               rd_metric,
  output logic [ROW_BITS_W-1:0] rd_bits
);

  localparam int BITMAP_DEPTH = GLYPH_COUNT * ROWS_PER_GLYPH;

  metric_t                 metric_mem [GLYPH_COUNT];
  logic [ROW_BITS_W-1:0]   bitmap_mem [BITMAP_DEPTH];
  logic [GLYPH_COUNT-1:0]  entry_valid;
  metric_t                 metric_q;
  logic                    valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ctl.wr_metric) begin
      entry_valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_metric) begin
      metric_mem[wr_idx] <= wr_metric;
    end
    if (ctl.rd_metric) begin
      metric_q <= metric_mem[wr_idx];
      valid_q  <= entry_valid[wr_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_row) begin
      bitmap_mem[{wr_idx, wr_row}] <= wr_bits;
    end
    rd_bits <= bitmap_mem[{rd_idx, rd_row}];
  end

  // An entry never loaded since reset reads as all zero: absent, no advance.
  assign rd_metric = valid_q ? metric_q : '0;

endmodule

// ===== rtl/bitmap_glyph_text_renderer_core.sv =====
// Top level of the bitmap glyph text renderer: sequencer, pen and output register.
// Depends on bgtr_pkg and bgtr_glyph_store.
//
// Usage:
//   Requests arrive on in_valid/in_stall with one field per port. Each request
//   loads glyph metrics, loads one glyph row, begins a text line or draws one
//   character. Configuration is written through cfg_write/cfg_index/cfg_data;
//   the user must write it only while the block is idle, which the block
//   itself does not enforce. Loads and begin text leave the block idle. A draw
//   first accepts the request and reads the metrics, then a setup step
//   computes the clip mask, first image row and new pen, then the single row
//   stepper walks the glyph rows. Each row inside the image goes out as one
//   request on out_valid/out_stall, top row first, with last_row set on the
//   final one. Rows outside the image are stepped over but produce nothing.
//   An absent glyph only moves the pen.
//   in_stall is high while a draw is in progress. The output register lets the
//   block accept its next request while the last result still waits; when the
//   receiver stalls, the row stepper holds until the register frees up.
//   Synchronous reset clears the pen, start position and metric valid bits and
//   sets the image size to 4096; the bitmap rows hold whatever was last written.
module bitmap_glyph_text_renderer_core import bgtr_pkg::*; #(
  parameter int GLYPH_COUNT = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [7:0]         char_code,
  input  logic [3:0]         row_index,
  input  logic [15:0]        row_bits,
  input  logic [4:0]         glyph_width,
  input  logic [4:0]         glyph_height,
  input  logic signed [7:0]  x_offset,
  input  logic signed [7:0]  y_offset,
  input  logic signed [7:0]  advance_x,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        pixel_y,
  output logic signed [15:0] pixel_x,
  output logic [15:0]        column_mask,
  output logic               last_row
);

  localparam int IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_ROW} state_t;

  state_t              state;
  logic signed [15:0]  start_x;
  logic signed [15:0]  start_y;
  logic [12:0]         image_width;
  logic [12:0]         image_height;
  logic signed [15:0]  pen_x;
  logic [IDX_W-1:0]    code_idx;
  logic [3:0]          py;
  logic [3:0]          h_m1;
  logic signed [17:0]  pos_y;
  logic signed [15:0]  row_x;
  logic [15:0]         col_ok;

  logic                accept;
  logic                in_range;
  store_ctl_t          ctl;
  metric_t             new_metric;
  metric_t             metric;
  logic [15:0]         rd_bits;
  logic [3:0]          rd_row;
  logic                can_emit;

  logic signed [17:0]  base_x;
  logic signed [15:0]  base_x_sat;
  logic signed [16:0]  pen_sum;
  logic signed [15:0]  pen_next;
  logic signed [17:0]  pos_y_first;
  logic [15:0]         col_ok_next;
  logic [4:0]          h_dec;
  logic [12:0]         ylim;
  logic                row_visible;
  logic                row_last;
  logic [15:0]         row_mask;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_range = ({1'b0, char_code} < 9'(GLYPH_COUNT));
  assign can_emit = !out_valid || !out_stall;

  assign ctl.wr_metric = accept && (op_t'(operation) == OP_LOAD_METRICS) && in_range;
  assign ctl.wr_row    = accept && (op_t'(operation) == OP_LOAD_ROW) && in_range;
  assign ctl.rd_metric = accept && (op_t'(operation) == OP_DRAW_CHAR);

  always_comb begin
    new_metric.present      = (glyph_width != 5'd0) && (glyph_width <= W_LIM) &&
                              (glyph_height != 5'd0) && (glyph_height <= H_LIM);
    new_metric.glyph_width  = glyph_width;
    new_metric.glyph_height = glyph_height;
    new_metric.x_offset     = x_offset;
    new_metric.y_offset     = y_offset;
    new_metric.advance_x    = advance_x;
  end

  // Present the next row address early so the registered read lines up with py.
  assign rd_row = (state == ST_ROW && can_emit) ? py + 4'd1 : py;

  bgtr_glyph_store #(
    .GLYPH_COUNT(GLYPH_COUNT),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .wr_idx   (char_code[IDX_W-1:0]),
    .wr_row   (row_index),
    .wr_bits  (row_bits),
    .wr_metric(new_metric),
    .rd_idx   (code_idx),
    .rd_row   (rd_row),
    .rd_metric(metric),
    .rd_bits  (rd_bits)
  );

  // Setup arithmetic, used once per character.
  always_comb begin
    base_x = {{2{pen_x[15]}}, pen_x} + {{10{metric.x_offset[7]}}, metric.x_offset};
    if (base_x[17:15] == 3'b000 || base_x[17:15] == 3'b111) begin
      base_x_sat = base_x[15:0];
    end else if (base_x[17]) begin
      base_x_sat = 16'sh8000;
    end else begin
      base_x_sat = 16'sh7fff;
    end

    pen_sum = {pen_x[15], pen_x} + {{9{metric.advance_x[7]}}, metric.advance_x};
    if (pen_sum[16] == pen_sum[15]) begin
      pen_next = pen_sum[15:0];
    end else if (pen_sum[16]) begin
      pen_next = 16'sh8000;
    end else begin
      pen_next = 16'sh7fff;
    end

    pos_y_first = {{2{start_y[15]}}, start_y} + {{10{metric.y_offset[7]}}, metric.y_offset}
                  + {13'd0, metric.glyph_height} - 18'sd1;
    h_dec = metric.glyph_height - 5'd1;

    // A column survives if it lies inside the glyph box and inside the image.
    for (int k = 0; k < 16; k++) begin
      logic signed [17:0] cx;
      cx = base_x + 18'(k);
      col_ok_next[k] = !cx[17] && (cx < $signed({5'd0, image_width})) &&
                       (5'(k) < metric.glyph_width);
    end
  end

  // Row stepper.
  always_comb begin
    ylim        = (image_height > Y_LIMIT) ? Y_LIMIT : image_height;
    row_visible = !pos_y[17] && (pos_y < $signed({5'd0, ylim}));
    // Image rows count down as glyph rows advance, so nothing after image row zero can be visible.
    row_last    = (py == h_m1) || (pos_y == 18'sd0);
    for (int k = 0; k < 16; k++) begin
      row_mask[k] = rd_bits[15-k] & col_ok[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      pen_x        <= '0;
      start_x      <= '0;
      start_y      <= '0;
      image_width  <= 13'd4096;
      image_height <= 13'd4096;
    end else begin
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_START_X:      start_x      <= cfg_data;
          CFG_START_Y:      start_y      <= cfg_data;
          CFG_IMAGE_WIDTH:  image_width  <= cfg_data[12:0];
          CFG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
          default: ;
        endcase
      end

      // The register empties when its request is taken, unless a visible row refills it.
      if (out_valid && !out_stall && !(state == ST_ROW && row_visible)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            code_idx <= char_code[IDX_W-1:0];
            py       <= 4'd0;
            if (op_t'(operation) == OP_BEGIN_TEXT) begin
              pen_x <= start_x;
            end else if (op_t'(operation) == OP_DRAW_CHAR && in_range) begin
              state <= ST_SETUP;
            end
          end
        end
        ST_SETUP: begin
          pen_x  <= pen_next;
          row_x  <= base_x_sat;
          col_ok <= col_ok_next;
          pos_y  <= pos_y_first;
          h_m1   <= h_dec[3:0];
          state  <= metric.present ? ST_ROW : ST_IDLE;
        end
        ST_ROW: begin
          if (can_emit) begin
            if (row_visible) begin
              out_valid   <= 1'b1;
              pixel_y     <= pos_y[11:0];
              pixel_x     <= row_x;
              column_mask <= row_mask;
              last_row    <= row_last;
            end
            py    <= py + 4'd1;
            pos_y <= pos_y - 18'sd1;
            if (py == h_m1) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/bgtr_checker.sv =====
// Port-level checks for the glyph renderer core, attached by the bind below.
// Depends on nothing but the core's port list.
module bgtr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [11:0]        pixel_y,
  input logic signed [15:0] pixel_x,
  input logic [15:0]        column_mask,
  input logic               last_row
);

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output request present after reset");

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_y) && $stable(pixel_x) &&
                               $stable(column_mask) && $stable(last_row))
    else $error("stalled output request changed");

  // New results only come out of a draw in progress.
  a_out_from_draw: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> $past(in_stall))
    else $error("result appeared while the block was idle");

  // While a row other than the final one is pending, the draw is not finished.
  a_busy_until_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_row |-> in_stall)
    else $error("block idle before the final row of a character");

endmodule

bind bitmap_glyph_text_renderer_core bgtr_checker u_bgtr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .pixel_y    (pixel_y),
  .pixel_x    (pixel_x),
  .column_mask(column_mask),
  .last_row   (last_row)
);
